### rtl/core/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way run merge unit
// Sizes of the run buffers, field widths and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

	localparam int MAX_RUNS    = 8;
	localparam int FIFO_DEPTH  = 4;
	localparam int VALUE_W     = 32;
	localparam int MAX_RESULTS = 32;

	localparam int RUN_W  = $clog2(MAX_RUNS);
	localparam int ACT_W  = $clog2(MAX_RUNS + 1);
	localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
	localparam int CFG_W  = 4;
	localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
	localparam int TREE_N = 1 << RUN_W;

	localparam logic [CFG_W-1:0]   RUNS_RESET = CFG_W'(2);
	localparam logic [VALUE_W-1:0] SIGN_FLIP  = {1'b1, {(VALUE_W - 1){1'b0}}};

	typedef enum logic {
		S_IDLE,
		S_EVAL
	} kwm_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // apply the input beat (store/close or stage a rejection)
		logic pop;       // pop the smallest head into the pending slot
		logic clear;     // clear fill levels and closed flags
		logic load_out;  // move the pending result into the output register
		logic out_last;  // burst_last for the result being moved
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic reject;    // input beat is rejected
		logic blocked;   // an open run in use has no head
		logic any_head;  // some run in use has a head
		logic all_done;  // popping now drains the whole merge
		logic out_free;  // output register can take a result this cycle
	} dp_sts_t;

endpackage

`default_nettype wire

### rtl/core/kwm_ctrl.sv
// ----------------------------------------------------------------------------
// kwm_ctrl: merge controller
// Sequences one input beat: apply it, then pop heads until the merge blocks,
// drains or hits the per-beat result limit, one per cycle as output allows.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_ctrl (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	input  wire  logic              in_valid,
	output logic                    in_ready,
	input  wire  kwm_pkg::dp_sts_t  sts,
	output kwm_pkg::dp_cmd_t        cmd
);

	import kwm_pkg::*;

	kwm_state_t        state_q, state_d;
	logic              pend_valid_q, pend_valid_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              limit;
	logic              stop;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pend_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			state_q      <= state_d;
			pend_valid_q <= pend_valid_d;
			cnt_q        <= cnt_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		pend_valid_d = pend_valid_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		in_ready     = 1'b0;
		limit        = (cnt_q == CNT_W'(MAX_RESULTS));
		stop         = limit || sts.blocked || !sts.any_head;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept   = 1'b1;
					pend_valid_d = sts.reject;
					cnt_d        = sts.reject ? CNT_W'(1) : '0;
					state_d      = S_EVAL;
				end
			end
			S_EVAL: begin
				// a held result leaves only when we know whether it is the last
				if (!pend_valid_q || sts.out_free) begin
					cmd.load_out = pend_valid_q;
					cmd.out_last = stop;
					if (stop) begin
						cmd.clear    = !limit && !sts.blocked && !sts.any_head;
						pend_valid_d = 1'b0;
						state_d      = S_IDLE;
					end else begin
						cmd.pop      = 1'b1;
						cmd.clear    = sts.all_done;
						pend_valid_d = 1'b1;
						cnt_d        = cnt_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d      = S_IDLE;
				pend_valid_d = 1'b0;
			end
		endcase
	end

	// checks
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result moved into a busy output register");

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("result count beyond limit");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("pending result left behind in idle");

	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && sts.all_done) |=> sts.blocked)
		else $error("merge not blocked after final element");

endmodule

`default_nettype wire

### rtl/core/kwm_datapath.sv
// ----------------------------------------------------------------------------
// kwm_datapath: run buffers, head selection and result registers
// Per-run shift FIFOs keep the head at slot zero; a compare tree picks the
// smallest head, lowest run on a tie.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_datapath (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          cfg_we,
	input  wire  logic [kwm_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire  logic [kwm_pkg::RUN_W-1:0]     run_index,
	input  wire  logic                          has_value,
	input  wire  logic signed [kwm_pkg::VALUE_W-1:0] element,
	input  wire  logic                          ends_run,
	input  wire  kwm_pkg::dp_cmd_t              cmd,
	output kwm_pkg::dp_sts_t                    sts,
	output logic                                out_valid,
	input  wire  logic                          out_ready,
	output logic signed [kwm_pkg::VALUE_W-1:0]  merged_value,
	output logic [kwm_pkg::RUN_W-1:0]           source_run,
	output logic                                merge_done,
	output logic                                dropped,
	output logic                                burst_last
);

	import kwm_pkg::*;

	typedef struct packed {
		logic               vld;
		logic [VALUE_W-1:0] key;
		logic [RUN_W-1:0]   idx;
	} cand_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RUN_W-1:0]   src;
		logic               done;
		logic               drop;
	} result_t;

	logic [CFG_W-1:0]   runs_q;
	logic [ACT_W-1:0]   k_act;
	logic [FILL_W-1:0]  fill_q [MAX_RUNS];
	logic [MAX_RUNS-1:0] closed_q;
	logic [VALUE_W-1:0] store_q [MAX_RUNS][FIFO_DEPTH];
	logic               out_valid_q;
	result_t            pend_q;
	cand_t              node [1:2*TREE_N-1];
	logic [RUN_W-1:0]   best;
	logic               post_empty;

	// runs in use, clamped to 1 .. MAX_RUNS
	always_comb begin
		if (runs_q == '0)
			k_act = ACT_W'(1);
		else if (int'(runs_q) > MAX_RUNS)
			k_act = ACT_W'(MAX_RUNS);
		else
			k_act = ACT_W'(runs_q);
	end

	// head compare tree, ties keep the left (lower) run
	always_comb begin
		for (int n = 1; n < 2 * TREE_N; n++)
			node[n] = '0;
		for (int i = 0; i < TREE_N; i++) begin
			if (i < MAX_RUNS) begin
				node[TREE_N + i].vld = (i < int'(k_act)) && (fill_q[i] != '0);
				node[TREE_N + i].key = store_q[i][0] ^ SIGN_FLIP;
				node[TREE_N + i].idx = RUN_W'(i);
			end
		end
		for (int n = TREE_N - 1; n >= 1; n--) begin
			if (node[2*n+1].vld && (!node[2*n].vld || (node[2*n+1].key < node[2*n].key)))
				node[n] = node[2*n+1];
			else
				node[n] = node[2*n];
		end
	end

	assign best = node[1].idx;

	// status: rejection of the current input beat, head and output room,
	// blocking runs and drain check after a pop of best
	always_comb begin
		sts.reject   = (int'(run_index) >= int'(k_act)) || closed_q[run_index] ||
			(has_value && (fill_q[run_index] == FILL_W'(FIFO_DEPTH)));
		sts.any_head = node[1].vld;
		sts.out_free = !out_valid_q || out_ready;
		sts.blocked  = 1'b0;
		sts.all_done = 1'b1;
		post_empty   = 1'b0;
		for (int i = 0; i < MAX_RUNS; i++) begin
			post_empty = (fill_q[i] == '0) ||
				((RUN_W'(i) == best) && (fill_q[i] == FILL_W'(1)));
			if (i < int'(k_act)) begin
				if ((fill_q[i] == '0) && !closed_q[i])
					sts.blocked = 1'b1;
				if (!post_empty || !closed_q[i])
					sts.all_done = 1'b0;
			end
		end
	end

	// config register, fill levels, closed flags, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_q      <= RUNS_RESET;
			closed_q    <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_RUNS; i++)
				fill_q[i] <= '0;
		end else begin
			if (cfg_we)
				runs_q <= cfg_wdata;
			if (cmd.clear) begin
				closed_q <= '0;
				for (int i = 0; i < MAX_RUNS; i++)
					fill_q[i] <= '0;
			end else if (cmd.pop) begin
				fill_q[best] <= fill_q[best] - FILL_W'(1);
			end else if (cmd.accept && !sts.reject) begin
				if (has_value)
					fill_q[run_index] <= fill_q[run_index] + FILL_W'(1);
				if (ends_run)
					closed_q[run_index] <= 1'b1;
			end
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// run storage: write at the tail, shift toward slot zero on pop
	always_ff @(posedge clk) begin
		if (cmd.accept && !sts.reject && has_value)
			store_q[run_index][fill_q[run_index][PTR_W-1:0]] <= element;
		if (cmd.pop) begin
			for (int j = 0; j < FIFO_DEPTH - 1; j++)
				store_q[best][j] <= store_q[best][j+1];
		end
	end

	// pending result and output register payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_q.value <= '0;
			pend_q.src   <= run_index;
			pend_q.done  <= 1'b0;
			pend_q.drop  <= 1'b1;
		end else if (cmd.pop) begin
			pend_q.value <= node[1].key ^ SIGN_FLIP;
			pend_q.src   <= best;
			pend_q.done  <= sts.all_done;
			pend_q.drop  <= 1'b0;
		end
		if (cmd.load_out) begin
			merged_value <= pend_q.value;
			source_run   <= pend_q.src;
			merge_done   <= pend_q.done;
			dropped      <= pend_q.drop;
			burst_last   <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/k_way_run_merge_unit.sv
// ----------------------------------------------------------------------------
// k_way_run_merge_unit: merges up to eight ascending runs into one stream
// Flow: a beat is taken in idle; a rejection result moves from the pending slot
//   into the output register, and each merged element is popped into the
//   pending slot and then moved on to the output register. A new beat is taken
//   only back in idle; heads are popped one per cycle while the output is free.
// Reset: asynchronous; clears fill levels, closed flags and handshakes,
//   runs_in_use returns to 2; run storage is left as is.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_run_merge_unit (
	input  wire  logic                               clk,
	input  wire  logic                               arst_n,
	input  wire  logic                               cfg_we,
	input  wire  logic [kwm_pkg::CFG_W-1:0]          cfg_wdata,
	input  wire  logic                               in_valid,
	output logic                                     in_ready,
	input  wire  logic [kwm_pkg::RUN_W-1:0]          run_index,
	input  wire  logic                               has_value,
	input  wire  logic signed [kwm_pkg::VALUE_W-1:0] element,
	input  wire  logic                               ends_run,
	output logic                                     out_valid,
	input  wire  logic                               out_ready,
	output logic signed [kwm_pkg::VALUE_W-1:0]       merged_value,
	output logic [kwm_pkg::RUN_W-1:0]                source_run,
	output logic                                     merge_done,
	output logic                                     dropped,
	output logic                                     burst_last
);

	import kwm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer
	kwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// buffers, compare tree, result registers
	kwm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.run_index    (run_index),
		.has_value    (has_value),
		.element      (element),
		.ends_run     (ends_run),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.merged_value (merged_value),
		.source_run   (source_run),
		.merge_done   (merge_done),
		.dropped      (dropped),
		.burst_last   (burst_last)
	);

endmodule

`default_nettype wire
